// ----- design/tsps_pkg.sv -----
// ----------------------------------------------------------------------------
// tsps_pkg: shared types and constants for the phase sequencer
// Word layouts, register indexes, reset values and the duration lookup.
// ----------------------------------------------------------------------------
package tsps_pkg;

    // Default build
    localparam int PHASES_DEF   = 4;
    localparam int CHANNELS_DEF = 8;

    // Widths fixed by the register and word layouts
    localparam int PHASE_W   = 3;   // holds any phase index up to eight phases
    localparam int DUR_W     = 8;
    localparam int LAMPS_W   = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_TIMES    = 2'd0,
        CFG_YELLOW_TIMES   = 2'd1,
        CFG_PHASE_CHANNELS = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic [31:0] GREEN_TIMES_RST    = 32'h0D0C_0B0A;
    localparam logic [31:0] YELLOW_TIMES_RST   = 32'h0202_0202;
    localparam logic [23:0] PHASE_CHANNELS_RST = 24'hF7_4650;

    // Lamp codes per channel: bit 0 green, bit 1 red, bit 2 yellow
    localparam logic [2:0] LAMP_GREEN  = 3'b001;
    localparam logic [2:0] LAMP_RED    = 3'b010;
    localparam logic [2:0] LAMP_YELLOW = 3'b100;

    // Input word
    typedef struct packed {
        logic second_elapsed;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [LAMPS_W-1:0] lamps;
        logic [1:0]         phase_now;
        logic               in_yellow;
        logic [DUR_W-1:0]   seconds_left;
        logic               all_zero;
    } t_out_word;

    // Sequencer state
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               yellow;
        logic [DUR_W-1:0]   remaining;
        logic               loaded;
    } t_state;

    // Duration of one interval; phase group taken modulo four
    function automatic logic [DUR_W-1:0] duration_of(
        input logic [31:0] green_times,
        input logic [31:0] yellow_times,
        input logic [1:0]  grp,
        input logic        yellow
    );
        logic [31:0] reg_sel;
        logic [31:0] shifted;
        reg_sel = yellow ? yellow_times : green_times;
        shifted = reg_sel >> {grp, 3'b000};
        return shifted[DUR_W-1:0];
    endfunction

endpackage

// ----- design/tsps_chan_if.sv -----
// ----------------------------------------------------------------------------
// tsps_chan_if: valid/ready channel
// Carries one word per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface tsps_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/traffic_signal_phase_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// traffic_signal_phase_sequencer_core: traffic signal phase sequencer
// Steps through the phases' green and yellow intervals and reports lamps.
// ----------------------------------------------------------------------------
// One input word yields exactly one result word. The step logic is combinational,
// so a word is taken every cycle while the skid stage is empty, and its result
// sits in the output register (or the skid stage behind it) in the cycle after
// acceptance. The output register is backed by a one-word skid stage: input
// ready drops only when both hold a word, i.e. from the cycle after the sink
// stalls on a held result while a new word is taken until a result is popped.
// Time writes apply to intervals loaded after them; channel writes at once.
module traffic_signal_phase_sequencer_core #(
    parameter int PHASES   = tsps_pkg::PHASES_DEF,
    parameter int CHANNELS = tsps_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsps_pkg::CFG_W-1:0]     i_cfg_data,
    tsps_chan_if.sink                     i_in,
    tsps_chan_if.source                   o_out
);

    logic [31:0]         r_green_times;
    logic [31:0]         r_yellow_times;
    logic [23:0]         r_phase_channels;
    tsps_pkg::t_state    r_state;
    tsps_pkg::t_state    step_state;
    tsps_pkg::t_out_word step_res;
    tsps_pkg::t_in_word  in_word;

    tsps_pkg::t_out_word r_out;
    tsps_pkg::t_out_word n_out;
    logic                r_out_valid;
    logic                n_out_valid;
    tsps_pkg::t_out_word r_skid;
    tsps_pkg::t_out_word n_skid;
    logic                r_skid_valid;
    logic                n_skid_valid;

    logic accept;
    logic pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_times    <= tsps_pkg::GREEN_TIMES_RST;
            r_yellow_times   <= tsps_pkg::YELLOW_TIMES_RST;
            r_phase_channels <= tsps_pkg::PHASE_CHANNELS_RST;
        end else if (i_cfg_we) begin
            unique case (tsps_pkg::t_cfg_idx'(i_cfg_idx))
                tsps_pkg::CFG_GREEN_TIMES:    r_green_times    <= i_cfg_data;
                tsps_pkg::CFG_YELLOW_TIMES:   r_yellow_times   <= i_cfg_data;
                tsps_pkg::CFG_PHASE_CHANNELS: r_phase_channels <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Handshakes
    assign in_word     = i_in.data;
    assign i_in.ready  = !r_skid_valid;
    assign accept      = i_in.valid && !r_skid_valid;
    assign pop         = r_out_valid && o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Step logic
    tsps_step #(
        .PHASES   (PHASES),
        .CHANNELS (CHANNELS)
    ) u_step (
        .i_state          (r_state),
        .i_green_times    (r_green_times),
        .i_yellow_times   (r_yellow_times),
        .i_phase_channels (r_phase_channels),
        .i_tick           (in_word.second_elapsed),
        .o_state          (step_state),
        .o_res            (step_res)
    );

    // Sequencer state advances on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= step_state;
        end
    end

    // Output register and skid stage
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (accept) begin
                n_out = step_res;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid) begin
                n_out       = step_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = step_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

// ----- design/tsps_step.sv -----
// ----------------------------------------------------------------------------
// tsps_step: one sequencer step
// From the current state, the registers and the tick flag, forms the result
// word and the next state. Purely combinational.
// ----------------------------------------------------------------------------
module tsps_step #(
    parameter int PHASES   = tsps_pkg::PHASES_DEF,
    parameter int CHANNELS = tsps_pkg::CHANNELS_DEF
) (
    input  tsps_pkg::t_state    i_state,
    input  logic [31:0]         i_green_times,
    input  logic [31:0]         i_yellow_times,
    input  logic [23:0]         i_phase_channels,
    input  logic                i_tick,
    output tsps_pkg::t_state    o_state,
    output tsps_pkg::t_out_word o_res
);

    localparam int PW = tsps_pkg::PHASE_W;
    localparam int DW = tsps_pkg::DUR_W;

    logic [PW-1:0] cur_p;
    logic          cur_y;
    logic          found;
    logic [PW-1:0] sel_p;
    logic          sel_y;
    logic [DW-1:0] sel_d;
    logic [PW:0]   add;
    logic [PW:0]   sum;
    logic          sy;
    logic [DW-1:0] d;

    logic          act;
    logic [PW-1:0] p;
    logic          y;
    logic [DW-1:0] rem;
    logic [DW-1:0] dec;
    logic [23:0]   grp_word;
    logic [2:0]    c0;
    logic [2:0]    c1;
    logic [23:0]   lamps;
    logic [23:0]   reds;

    // Current position, forced back into range
    always_comb begin
        cur_p = ({1'b0, i_state.phase} >= (PW+1)'(PHASES)) ? '0 : i_state.phase;
        cur_y = i_state.yellow;
    end

    // Forward search for the first interval with a nonzero duration
    always_comb begin
        found = 1'b0;
        sel_p = cur_p;
        sel_y = cur_y;
        sel_d = '0;
        add   = '0;
        sum   = '0;
        sy    = 1'b0;
        d     = '0;
        for (int n = 0; n < 2*PHASES; n++) begin
            add = (PW+1)'((int'(cur_y) + n) >> 1);
            sum = {1'b0, cur_p} + add;
            if (sum >= (PW+1)'(PHASES)) begin
                sum = sum - (PW+1)'(PHASES);
            end
            sy = cur_y ^ 1'(n);
            d  = tsps_pkg::duration_of(i_green_times, i_yellow_times, sum[1:0], sy);
            if (!found && d != '0) begin
                found = 1'b1;
                sel_p = sum[PW-1:0];
                sel_y = sy;
                sel_d = d;
            end
        end
    end

    // Interval in force for this word
    always_comb begin
        if (i_state.loaded) begin
            act = 1'b1;
            p   = cur_p;
            y   = cur_y;
            rem = i_state.remaining;
        end else begin
            act = found;
            p   = sel_p;
            y   = sel_y;
            rem = sel_d;
        end
    end

    // Lamp word: bound channels green or yellow, the rest of the CHANNELS red
    always_comb begin
        grp_word = i_phase_channels >> (5'(p[1:0]) * 5'd6);
        c0       = grp_word[2:0];
        c1       = grp_word[5:3];
        lamps    = '0;
        reds     = '0;
        for (int c = 0; c < 8; c++) begin
            if (c < CHANNELS) begin
                reds[3*c +: 3] = tsps_pkg::LAMP_RED;
                if (c0 == 3'(c) || c1 == 3'(c)) begin
                    lamps[3*c +: 3] = y ? tsps_pkg::LAMP_YELLOW : tsps_pkg::LAMP_GREEN;
                end else begin
                    lamps[3*c +: 3] = tsps_pkg::LAMP_RED;
                end
            end
        end
    end

    // Result word
    always_comb begin
        o_res.phase_now = 2'(p);
        o_res.in_yellow = y;
        if (act) begin
            o_res.lamps        = lamps;
            o_res.seconds_left = rem;
            o_res.all_zero     = 1'b0;
        end else begin
            o_res.lamps        = reds;
            o_res.seconds_left = '0;
            o_res.all_zero     = 1'b1;
        end
    end

    // Next state: count down on a tick, step on at interval end
    always_comb begin
        dec               = rem - DW'(rem != '0);
        o_state.phase     = p;
        o_state.yellow    = y;
        o_state.remaining = rem;
        o_state.loaded    = act;
        if (act && i_tick) begin
            o_state.remaining = dec;
            if (dec == '0) begin
                o_state.loaded = 1'b0;
                if (!y) begin
                    o_state.yellow = 1'b1;
                end else begin
                    o_state.yellow = 1'b0;
                    o_state.phase  = ({1'b0, p} + 1'b1 >= (PW+1)'(PHASES)) ?
                                     '0 : p + 1'b1;
                end
            end
        end
    end

endmodule
